FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mm2_pkg.sv
// ---------------------------------------------------------------------------
// mm2_pkg
// Types, constants and helpers shared by the MurmurHash2 engine modules.
// ---------------------------------------------------------------------------
package mm2_pkg;

    localparam int WORD_W    = 32;
    localparam int NBYTES_W  = 3;
    localparam int LEN_W     = 31;
    localparam int HASH_W    = 32;
    localparam int S_TDATA_W = 72;

    localparam int NB_LSB    = WORD_W;
    localparam int LEN_LSB   = WORD_W + NBYTES_W;

    localparam logic [WORD_W-1:0] MIX_MULT   = 32'h5bd1_e995;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'd97;
    localparam int MIX_SHIFT   = 24;
    localparam int FIN_SHIFT_A = 13;
    localparam int FIN_SHIFT_B = 15;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TAIL,
        OP_WORD
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY1,
        S_KEY2,
        S_HASH,
        S_FIN
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [WORD_W-1:0]  word;
        logic               first;
        logic               last;
        logic [WORD_W-1:0]  init;
    } t_entry;

    // Mask that keeps the valid low bytes of a short tail word.
    function automatic logic [WORD_W-1:0] f_tail_mask(input logic [NBYTES_W-1:0] nb);
        logic [WORD_W-1:0] m;
        case (nb)
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            3'd0:    m = 32'h0000_0000;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

FILE: hdl/mm2_front.sv
// ---------------------------------------------------------------------------
// mm2_front
// Accepts input words, holds the seed and classifies each word for the back end.
// ---------------------------------------------------------------------------
module mm2_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mm2_pkg::WORD_W-1:0]          i_cfg_data,
    input  logic                                i_tvalid,
    output logic                                o_tready,
    input  logic [mm2_pkg::S_TDATA_W-1:0]       i_tdata,
    input  logic                                i_tlast,
    input  logic                                i_tuser,
    input  logic                                i_full,
    output logic                                o_push,
    output mm2_pkg::t_entry                     o_entry
);
    import mm2_pkg::*;

    logic [WORD_W-1:0]   r_seed;
    logic [WORD_W-1:0]   word;
    logic [NBYTES_W-1:0] nb;
    logic [LEN_W-1:0]    len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_data;
        end
    end

    assign word     = i_tdata[NB_LSB-1:0];
    assign nb       = i_tdata[LEN_LSB-1:NB_LSB];
    assign len      = i_tdata[LEN_LSB+LEN_W-1:LEN_LSB];
    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;

    // Byte counts above four count as a full word.
    always_comb begin
        o_entry.word  = word & f_tail_mask(nb);
        o_entry.first = i_tuser;
        o_entry.last  = i_tlast;
        o_entry.init  = r_seed ^ {1'b0, len};
        if (nb >= 3'd4) begin
            o_entry.op = OP_WORD;
        end else if (nb == 3'd0) begin
            o_entry.op = OP_NONE;
        end else begin
            o_entry.op = OP_TAIL;
        end
    end

endmodule

FILE: hdl/mm2_queue.sv
// ---------------------------------------------------------------------------
// mm2_queue
// Short register queue of classified words between front and back end.
// ---------------------------------------------------------------------------
module mm2_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mm2_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output mm2_pkg::t_entry o_entry,
    output logic            o_empty
);
    import mm2_pkg::*;

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;

    function automatic logic [Q_PTR_W-1:0] f_next(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/mm2_back.sv
// ---------------------------------------------------------------------------
// mm2_back
// Mixing sequencer around one shared constant multiplier, with output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mm2_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  mm2_pkg::t_entry               i_entry,
    output logic                          o_pop,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [mm2_pkg::HASH_W-1:0]    o_hash
);
    import mm2_pkg::*;

    t_state             r_state, n_state;
    logic [WORD_W-1:0]  r_h, n_h;
    logic [WORD_W-1:0]  r_k, n_k;
    logic               r_last, n_last;
    logic               r_out_valid, n_out_valid;
    logic [HASH_W-1:0]  r_out_hash;
    logic [WORD_W-1:0]  mul_a;
    logic [WORD_W-1:0]  prod;
    logic [WORD_W-1:0]  fin_x;
    logic [WORD_W-1:0]  base_h;
    logic               out_free;
    logic               ld_out;
    logic               hold_h;

    assign out_free = !r_out_valid || i_tready;
    assign fin_x    = r_h ^ (r_h >> FIN_SHIFT_A);
    assign prod     = mul_a * MIX_MULT;
    assign base_h   = i_entry.first ? i_entry.init : r_h;
    assign hold_h   = (r_state == S_KEY1) || (r_state == S_KEY2) || (r_state == S_FIN);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    case (i_entry.op)
                        OP_WORD: n_state = S_KEY1;
                        OP_TAIL: n_state = S_HASH;
                        default: n_state = i_entry.last ? S_FIN : S_IDLE;
                    endcase
                end
            end
            S_KEY1:  n_state = S_KEY2;
            S_KEY2:  n_state = S_HASH;
            S_HASH:  n_state = r_last ? S_FIN : S_IDLE;
            S_FIN:   n_state = out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop  = 1'b0;
        ld_out = 1'b0;
        mul_a  = fin_x;
        case (r_state)
            S_IDLE:  o_pop = !i_empty;
            S_KEY1:  mul_a = r_k;
            S_KEY2:  mul_a = r_k;
            S_HASH:  mul_a = r_h;
            S_FIN:   ld_out = out_free;
            default: mul_a = fin_x;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_h    = r_h;
        n_k    = r_k;
        n_last = r_last;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_last = i_entry.last;
                    n_h    = (i_entry.op == OP_TAIL) ? (base_h ^ i_entry.word) : base_h;
                    n_k    = (i_entry.op == OP_WORD) ? i_entry.word : '0;
                end
            end
            S_KEY1:  n_k = prod ^ (prod >> MIX_SHIFT);
            S_KEY2:  n_k = prod;
            S_HASH:  n_h = prod ^ r_k;
            default: n_h = r_h;
        endcase
        n_out_valid = ld_out ? 1'b1 : (i_tready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_last <= n_last;
        if (ld_out) begin
            r_out_hash <= prod ^ (prod >> FIN_SHIFT_B);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_h         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_h         <= n_h;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_hash   = r_out_hash;

    `ASSERT_NOW(a_pop_needs_data, o_pop, !i_empty, "pop from an empty queue")
    `ASSERT_NEXT(a_fin_loads_out, ld_out, r_out_valid, "finalized hash not presented")
    `ASSERT_NEXT(a_key_keeps_hash, hold_h, $stable(r_h), "running hash changed outside a hash step")
    `ASSERT_NOW(a_fin_waits_slot, (r_state == S_FIN) && !out_free, !ld_out, "output overwritten")

endmodule

FILE: hdl/murmur2_hash_engine.sv
// ---------------------------------------------------------------------------
// murmur2_hash_engine
// 32-bit MurmurHash2 over a message streamed as little-endian 32-bit words.
// ---------------------------------------------------------------------------
//
// Channel    Dir  Handshake                      Carries
// s_axis     in   s_axis_tvalid/s_axis_tready    message word, byte count, length
// m_axis     out  m_axis_tvalid/m_axis_tready    finalized hash, one per message
// cfg        in   i_cfg_valid/o_cfg_ready        seed value
//
// The front end classifies each word and pushes it into a two-entry queue; the
// back end works through the queue with one shared 32-bit constant multiplier.
// A full word passes through KEY1, KEY2 and HASH after its pop in IDLE, a tail
// word through HASH only, an empty word through none of them; the last word of a
// message adds finalization in FIN; the multiplier does one multiply per cycle.
// Reset is synchronous and active low; it empties the queue, returns the
// sequencer to idle, drops the output word and loads the seed with 97.
// The input side stalls only when the queue is full; the hash waits in its
// output register while the back end goes on with the next message.
// ---------------------------------------------------------------------------
module murmur2_hash_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Seed write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mm2_pkg::WORD_W-1:0]          i_cfg_data,
    // Input words.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: word [31:0], nbytes [34:32], total_len [65:35], zero [71:66]
    input  logic [mm2_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                s_axis_tlast,
    // tuser: first [0]
    input  logic                                s_axis_tuser,
    // Result words.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: hash [31:0]
    output logic [mm2_pkg::HASH_W-1:0]          m_axis_tdata
);
    import mm2_pkg::*;

    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;

    // The front end owns the seed and decides how each word is mixed.
    mm2_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tlast     (s_axis_tlast),
        .i_tuser     (s_axis_tuser),
        .i_full      (q_full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    mm2_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_empty (q_empty)
    );

    // The back end keeps the running hash and emits the finalized value.
    mm2_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_hash   (m_axis_tdata)
    );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the MurmurHash2 engine: a queue-fed stream driver,
// a hash predictor kept in step with every accepted word, and a monitor that
// compares each result word with the oldest predicted hash.
// ---------------------------------------------------------------------------
module testbench;

    import mm2_pkg::*;

    // One input word as the sender sees it, before packing onto the bus.
    typedef struct {
        logic [WORD_W-1:0]   word;
        logic [NBYTES_W-1:0] nbytes;
        logic                first;
        logic                last;
        logic [LEN_W-1:0]    len;
    } t_hash_item;

    // Clock, reset and all block inputs start at known values.
    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [WORD_W-1:0]    cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic [S_TDATA_W-1:0] in_data   = '0;
    logic                 in_last   = 1'b0;
    logic                 in_first  = 1'b0;
    logic                 out_ready = 1'b0;

    logic                 o_cfg_ready;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [HASH_W-1:0]    m_axis_tdata;

    murmur2_hash_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (in_data),      // word [31:0], nbytes [34:32], total_len [65:35]
        .s_axis_tlast  (in_last),
        .s_axis_tuser  (in_first),     // first [0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (m_axis_tdata)  // hash [31:0]
    );

    // Words waiting to be sent, and hashes waiting to come out.
    t_hash_item        send_queue[$];
    logic [HASH_W-1:0] hash_expect[$];

    // Predictor state: the seed register and the unfinalized running hash.
    logic [WORD_W-1:0] seed_val = SEED_RESET;
    logic [WORD_W-1:0] acc_hash = '0;

    int n_words_sent   = 0;
    int n_hash_checked = 0;
    int n_queued       = 0;
    int n_seeds        = 0;
    int n_errors       = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Every failure funnels through here; only the first ten are spelled out.
    task automatic report_error(input string what, input logic [HASH_W-1:0] exp_v,
                                input logic [HASH_W-1:0] act_v);
        n_errors++;
        if (n_errors <= 10) begin
            $display("ERROR %0t: %s expected %08h got %08h", $realtime, what, exp_v, act_v);
        end
    endtask

    // Fold one accepted word into the running hash. A first word reloads the
    // hash from the seed and the declared length; a full word goes through the
    // key mix, a short word is masked to its valid low bytes and multiplied in.
    // Byte counts above four behave as four. The last word finalizes a copy of
    // the hash and queues it as the expected result; the running hash itself
    // stays unfinalized so a word without first continues from it.
    task automatic fold_word(input t_hash_item it);
        logic [WORD_W-1:0]   h;
        logic [WORD_W-1:0]   k;
        logic [WORD_W-1:0]   mask;
        logic [WORD_W-1:0]   fin;
        logic [NBYTES_W-1:0] nb;
        nb = (it.nbytes > 3'd4) ? 3'd4 : it.nbytes;
        h  = it.first ? (seed_val ^ {1'b0, it.len}) : acc_hash;
        if (nb == 3'd4) begin
            k = it.word * MIX_MULT;
            k = k ^ (k >> MIX_SHIFT);
            k = k * MIX_MULT;
            h = (h * MIX_MULT) ^ k;
        end else if (nb != 3'd0) begin
            mask = (32'h1 << (8 * nb)) - 32'h1;
            h    = (h ^ (it.word & mask)) * MIX_MULT;
        end
        acc_hash = h;
        if (it.last) begin
            fin = h ^ (h >> FIN_SHIFT_A);
            fin = fin * MIX_MULT;
            fin = fin ^ (fin >> FIN_SHIFT_B);
            hash_expect = {hash_expect, fin};
        end
    endtask

    // Sender: works in bursts of random length separated by random gaps. A gap
    // of zero gives stretches where words follow back to back.
    t_hash_item cur_item;
    int         burst_left = 8;
    int         gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && s_axis_tready) begin
                fold_word(cur_item);
                n_words_sent++;
            end
            if (!in_valid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (send_queue.size() > 0) begin
                    cur_item = send_queue.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= {6'b0, cur_item.len, cur_item.nbytes, cur_item.word};
                    in_last  <= cur_item.last;
                    in_first <= cur_item.first;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: changes its stall behavior every so often. It may be always
    // ready, randomly ready, ready on a regular tick pattern, or hold off for long runs.
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_hold      = 0;
    int rx_tick      = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            rx_tick++;
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(40, 250);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= (rx_tick % 4 == 0);
                default: begin
                    if (rx_hold > 0) begin
                        rx_hold--;
                        out_ready <= 1'b0;
                    end else begin
                        rx_hold = $urandom_range(0, 15);
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Result monitor: every accepted hash word must match the oldest prediction.
    logic [HASH_W-1:0] exp_hash;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && out_ready) begin
            if (hash_expect.size() == 0) begin
                report_error("unexpected hash word", '0, m_axis_tdata);
            end else begin
                exp_hash = hash_expect.pop_front();
                n_hash_checked++;
                if (m_axis_tdata !== exp_hash) begin
                    report_error("hash mismatch", exp_hash, m_axis_tdata);
                end
            end
        end
    end

    task automatic add_item(input logic [WORD_W-1:0] w, input logic [NBYTES_W-1:0] nb,
                            input logic f, input logic l, input logic [LEN_W-1:0] len);
        t_hash_item it;
        it.word   = w;
        it.nbytes = nb;
        it.first  = f;
        it.last   = l;
        it.len    = len;
        send_queue = {send_queue, it};
        n_queued++;
    endtask

    // Splits a message of nbytes_total bytes into full words and at most one tail word.
    // An empty message is a single word with no valid bytes. Upper bytes of the
    // tail word carry random junk that the block must ignore.
    task automatic add_message(input int nbytes_total, input logic [LEN_W-1:0] len_field,
                               input logic with_first);
        int                  left;
        logic [NBYTES_W-1:0] nb;
        logic                is_first;
        left     = nbytes_total;
        is_first = with_first;
        if (left == 0) begin
            add_item($urandom, 3'd0, is_first, 1'b1, len_field);
        end else begin
            while (left > 0) begin
                nb   = (left >= 4) ? 3'd4 : 3'(left);
                left -= nb;
                add_item($urandom, nb, is_first, left == 0, len_field);
                is_first = 1'b0;
            end
        end
    endtask

    // Waits until every word is sent and every hash has arrived, then lets the
    // back end finish words that produce no hash before anything else happens.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (send_queue.size() > 0 || in_valid || hash_expect.size() > 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [WORD_W-1:0] v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        seed_val = v;
        n_seeds++;
    endtask

    // Mostly well-formed messages with random content and lengths, some with a
    // length field that disagrees with the bytes sent, plus broken messages and
    // pure noise words with any byte count and flags.
    task automatic add_random_phase(input int target);
        int                pick;
        int                nbytes_total;
        logic [LEN_W-1:0]  len_field;
        target += n_queued;
        while (n_queued < target) begin
            pick         = $urandom_range(0, 99);
            nbytes_total = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 256)
                                                       : $urandom_range(0, 24);
            len_field    = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom)
                                                       : LEN_W'(nbytes_total);
            if (pick < 75) begin
                add_message(nbytes_total, len_field, 1'b1);
            end else if (pick < 82) begin
                // Message that never had its first word.
                add_message(nbytes_total, len_field, 1'b0);
            end else if (pick < 90) begin
                // Short or empty word ahead of the rest of the message.
                add_item($urandom, 3'($urandom_range(0, 3)), 1'b1, 1'b0, len_field);
                add_message(nbytes_total, len_field, 1'b0);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    add_item($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), LEN_W'($urandom));
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, run with the seed at its reset value.
        // A last word right after reset, with no first: continues from zero.
        add_item(32'hdead_beef, 3'd4, 1'b0, 1'b1, '0);
        // Empty messages with the smallest and largest length fields.
        add_item(32'hffff_ffff, 3'd0, 1'b1, 1'b1, '0);
        add_item(32'h0000_0000, 3'd0, 1'b1, 1'b1, 31'h7fff_ffff);
        // One full word, all ones and then all zeros.
        add_item(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 31'd4);
        add_item(32'h0000_0000, 3'd4, 1'b1, 1'b1, 31'd4);
        // Full word then tails of one, two and three bytes with junk above.
        add_item(32'h0123_4567, 3'd4, 1'b1, 1'b0, 31'd5);
        add_item(32'hffff_ff5a, 3'd1, 1'b0, 1'b1, 31'd5);
        add_item(32'h89ab_cdef, 3'd4, 1'b1, 1'b0, 31'd6);
        add_item(32'hffff_a55a, 3'd2, 1'b0, 1'b1, 31'd6);
        add_item(32'h7654_3210, 3'd4, 1'b1, 1'b0, 31'd7);
        add_item(32'hff12_3456, 3'd3, 1'b0, 1'b1, 31'd7);
        // Byte counts five to seven behave as four.
        add_item(32'h1357_9bdf, 3'd5, 1'b1, 1'b1, 31'd4);
        add_item(32'h2468_ace0, 3'd6, 1'b1, 1'b0, 31'd8);
        add_item(32'hfedc_ba98, 3'd7, 1'b0, 1'b1, 31'd8);
        // Short word that is not last, then the message goes on.
        add_item(32'hcafe_f00d, 3'd2, 1'b1, 1'b0, 31'd10);
        add_item(32'h0bad_c0de, 3'd4, 1'b0, 1'b0, 31'd10);
        // Word with no valid bytes in the middle changes nothing.
        add_item(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 31'd10);
        add_item(32'h8000_0001, 3'd4, 1'b0, 1'b1, 31'd10);
        // Words without first after a finished message carry its state on.
        add_item(32'h5555_aaaa, 3'd4, 1'b0, 1'b0, 31'h2aaa_aaaa);
        add_item(32'haaaa_5555, 3'd3, 1'b0, 1'b1, 31'h5555_5555);
        // Length field that disagrees with the bytes sent.
        add_item(32'h1111_2222, 3'd4, 1'b1, 1'b1, 31'h4000_0000);
        wait_drained();

        // Random phases, each under a different seed including both extremes.
        write_seed(32'h0000_0000);
        @(negedge i_clk);
        add_random_phase(200);
        wait_drained();

        write_seed(32'hffff_ffff);
        @(negedge i_clk);
        add_random_phase(200);
        wait_drained();

        repeat (3) begin
            write_seed($urandom);
            @(negedge i_clk);
            add_random_phase(200);
            wait_drained();
        end

        write_seed(SEED_RESET);
        @(negedge i_clk);
        add_random_phase(200);
        wait_drained();

        if (hash_expect.size() > 0) begin
            report_error("hash never delivered", hash_expect[0], '0);
        end

        $display("Sent %0d input words and checked %0d hashes.", n_words_sent, n_hash_checked);
        $display("Seed register written %0d times; %0d errors seen.", n_seeds, n_errors);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
